// ===== src/ptq_pkg.sv =====
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types and constants for the periodic timer queue: the timer entry
// carried along the cell chain, the per-cycle chain command and status codes.
// ----------------------------------------------------------------------------
package ptq_pkg;

  localparam int TIME_W   = 32;
  localparam int TASK_W   = 8;
  localparam int PERIOD_W = 16;

  // most timers reported per tick; the re-arm buffer holds this many
  localparam int MAX_RESULTS = 16;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // result status codes
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_EXPIRED  = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  // input action codes
  localparam logic ACT_SCHEDULE = 1'b0;
  localparam logic ACT_TICK     = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]   expiry;
    logic [TASK_W-1:0]   task_id;
    logic [PERIOD_W-1:0] period;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t op;
    entry_t   ins;
  } cell_cmd_t;

endpackage

// ===== src/ptq_cell.sv =====
// ----------------------------------------------------------------------------
// ptq_cell
// One slot of the sorted timer chain. On insert a slot keeps its entry,
// loads the new one, or takes its left neighbor's; on pop it takes its
// right neighbor's.
// ----------------------------------------------------------------------------
module ptq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ptq_pkg::cell_cmd_t  cmd,
  input  logic                prev_take,
  input  logic                prev_valid,
  input  ptq_pkg::entry_t     prev_entry,
  input  logic                next_valid,
  input  ptq_pkg::entry_t     next_entry,
  output logic                take,
  output logic                valid,
  output ptq_pkg::entry_t     entry
);

  logic             valid_r;
  logic             valid_nxt;
  ptq_pkg::entry_t  entry_r;
  ptq_pkg::entry_t  entry_nxt;

  // slot lies at or past the insert point: empty, or expires later
  assign take = !(valid_r && (entry_r.expiry <= cmd.ins.expiry));

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    unique case (cmd.op)
      ptq_pkg::CELL_INSERT: begin
        if (take) begin
          if (prev_take) begin
            valid_nxt = prev_valid;
            entry_nxt = prev_entry;
          end else begin
            valid_nxt = 1'b1;
            entry_nxt = cmd.ins;
          end
        end
      end
      ptq_pkg::CELL_POP: begin
        valid_nxt = next_valid;
        entry_nxt = next_entry;
      end
      default: begin
        valid_nxt = valid_r;
        entry_nxt = entry_r;
      end
    endcase
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign valid = valid_r;
  assign entry = entry_r;

endmodule

// ===== src/periodic_timer_queue.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_queue
// Sorted list of timers held in a chain of slots, with a saturating tick count.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A schedule word keeps
// busy high through its insert state and gives one result in the cycle after
// it. A tick word keeps busy high while the timers that expire (at most 16)
// leave the chain and those of them that re-arm go back into it: the chain
// pops one expired timer from its head per cycle, reporting it in the next
// cycle, and then inserts one re-armed timer per cycle. Results of one tick
// come on consecutive cycles, one per cycle; out_last marks the final one.
// There is no backpressure on results: each is shown for exactly one cycle.
module periodic_timer_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_task_id,
  input  logic [15:0] in_delay,
  input  logic [15:0] in_interval,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_task_id_res,
  output logic        out_last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCHED,
    S_POP,
    S_REARM
  } state_t;

  state_t state_r;

  logic [ptq_pkg::TIME_W-1:0]   time_r;
  ptq_pkg::entry_t              sched_r;
  logic [ptq_pkg::RES_IDX_W-1:0] pop_cnt_r;
  logic [ptq_pkg::RES_CNT_W-1:0] re_cnt_r;
  logic [ptq_pkg::RES_IDX_W-1:0] re_rd_r;
  logic [ptq_pkg::TASK_W-1:0]   re_task_r   [ptq_pkg::MAX_RESULTS];
  logic [ptq_pkg::PERIOD_W-1:0] re_period_r [ptq_pkg::MAX_RESULTS];

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [7:0]  out_task_r;
  logic        out_last_r;

  logic                       cell_valid [QUEUE_DEPTH];
  ptq_pkg::entry_t            cell_entry [QUEUE_DEPTH];
  logic                       cell_take  [QUEUE_DEPTH];
  ptq_pkg::cell_cmd_t         cmd;

  logic accept;
  logic full;
  logic head_due;
  logic second_due;
  logic pop_last;
  logic pop_rearm;
  logic rearm_done;
  logic [ptq_pkg::RES_CNT_W-1:0] re_cnt_nxt;
  logic [ptq_pkg::TIME_W+1:0]    sched_sum;
  logic [ptq_pkg::TIME_W-1:0]    sched_exp;
  logic [ptq_pkg::TIME_W:0]      rearm_sum;
  ptq_pkg::entry_t               rearm_entry;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign full   = cell_valid[QUEUE_DEPTH-1];

  // first expiry of a new timer, saturating
  assign sched_sum = {2'b00, time_r} + (ptq_pkg::TIME_W+2)'(in_delay)
                   + (ptq_pkg::TIME_W+2)'(in_interval);
  assign sched_exp = (sched_sum[ptq_pkg::TIME_W+1:ptq_pkg::TIME_W] != 2'b00) ?
                     ptq_pkg::TIME_MAX : sched_sum[ptq_pkg::TIME_W-1:0];

  // re-armed timer at now plus its period, saturating
  assign rearm_sum = {1'b0, time_r} + (ptq_pkg::TIME_W+1)'(re_period_r[re_rd_r]);
  always_comb begin
    rearm_entry.expiry  = rearm_sum[ptq_pkg::TIME_W] ? ptq_pkg::TIME_MAX :
                          rearm_sum[ptq_pkg::TIME_W-1:0];
    rearm_entry.task_id = re_task_r[re_rd_r];
    rearm_entry.period  = re_period_r[re_rd_r];
  end
  assign rearm_done = (({1'b0, re_rd_r} + ptq_pkg::RES_CNT_W'(1)) == re_cnt_r);

  // head of chain: due now, and whether the next one is due too
  assign head_due   = cell_valid[0] && (cell_entry[0].expiry <= time_r);
  assign second_due = cell_valid[1] && (cell_entry[1].expiry <= time_r);
  assign pop_last   = !second_due ||
                      (pop_cnt_r == ptq_pkg::RES_IDX_W'(ptq_pkg::MAX_RESULTS - 1));
  assign pop_rearm  = (cell_entry[0].period != '0);
  assign re_cnt_nxt = re_cnt_r + ptq_pkg::RES_CNT_W'(pop_rearm);

  // chain command
  always_comb begin
    cmd.op  = ptq_pkg::CELL_HOLD;
    cmd.ins = sched_r;
    unique case (state_r)
      S_SCHED: begin
        if (!full) cmd.op = ptq_pkg::CELL_INSERT;
      end
      S_POP: begin
        if (head_due) cmd.op = ptq_pkg::CELL_POP;
      end
      S_REARM: begin
        cmd.op  = ptq_pkg::CELL_INSERT;
        cmd.ins = rearm_entry;
      end
      default: begin
        cmd.op = ptq_pkg::CELL_HOLD;
      end
    endcase
  end

  // the chain of slots
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic            prev_take;
    logic            prev_valid;
    ptq_pkg::entry_t prev_entry;
    logic            next_valid;
    ptq_pkg::entry_t next_entry;

    if (i == 0) begin : g_first
      assign prev_take  = 1'b0;
      assign prev_valid = 1'b0;
      assign prev_entry = '0;
    end else begin : g_inner_l
      assign prev_take  = cell_take[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_entry = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_entry = '0;
    end else begin : g_inner_r
      assign next_valid = cell_valid[i+1];
      assign next_entry = cell_entry[i+1];
    end

    ptq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_take  (prev_take),
      .prev_valid (prev_valid),
      .prev_entry (prev_entry),
      .next_valid (next_valid),
      .next_entry (next_entry),
      .take       (cell_take[i]),
      .valid      (cell_valid[i]),
      .entry      (cell_entry[i])
    );
  end

  // sequencer, tick count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      time_r      <= '0;
      pop_cnt_r   <= '0;
      re_cnt_r    <= '0;
      re_rd_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            pop_cnt_r <= '0;
            re_cnt_r  <= '0;
            re_rd_r   <= '0;
            if (in_action == ptq_pkg::ACT_TICK) begin
              if (time_r != ptq_pkg::TIME_MAX) time_r <= time_r + ptq_pkg::TIME_W'(1);
              state_r <= S_POP;
            end else begin
              state_r <= S_SCHED;
            end
          end
        end
        S_SCHED: begin
          out_valid_r  <= 1'b1;
          out_status_r <= full ? ptq_pkg::ST_DROPPED : ptq_pkg::ST_ACCEPTED;
          out_task_r   <= sched_r.task_id;
          out_last_r   <= 1'b1;
          state_r      <= S_IDLE;
        end
        S_POP: begin
          out_valid_r <= 1'b1;
          if (!head_due) begin
            out_status_r <= ptq_pkg::ST_NONE;
            out_task_r   <= '0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            out_status_r <= ptq_pkg::ST_EXPIRED;
            out_task_r   <= cell_entry[0].task_id;
            out_last_r   <= pop_last;
            pop_cnt_r    <= pop_cnt_r + ptq_pkg::RES_IDX_W'(1);
            re_cnt_r     <= re_cnt_nxt;
            if (pop_last) begin
              state_r <= (re_cnt_nxt != '0) ? S_REARM : S_IDLE;
            end
          end
        end
        S_REARM: begin
          re_rd_r <= re_rd_r + ptq_pkg::RES_IDX_W'(1);
          if (rearm_done) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // schedule word held for the insert cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      sched_r.expiry  <= sched_exp;
      sched_r.task_id <= in_task_id;
      sched_r.period  <= in_interval;
    end
  end

  // re-arm buffer, filled in firing order
  always_ff @(posedge clk) begin
    if ((state_r == S_POP) && head_due && pop_rearm) begin
      re_task_r[re_cnt_r[ptq_pkg::RES_IDX_W-1:0]]   <= cell_entry[0].task_id;
      re_period_r[re_cnt_r[ptq_pkg::RES_IDX_W-1:0]] <= cell_entry[0].period;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_task_id_res = out_task_r;
  assign out_last        = out_last_r;

endmodule

// ===== src/ptq_checker.sv =====
// ----------------------------------------------------------------------------
// ptq_checker
// Port-level checks on the timer queue: busy after a taken word, result
// bursts of a tick and the codes that close them.
// ----------------------------------------------------------------------------
module ptq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [7:0] out_task_id_res,
  input logic       out_last
);

  // a taken word keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after a taken word");

  // a result that is not the last is followed at once by another
  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a result burst");

  // the block stays busy while a burst is still open
  a_busy_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("block idle with a burst still open");

  // only expired timers can be followed by further results
  a_single_results_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ptq_pkg::ST_EXPIRED)) |-> out_last)
    else $error("non-expiry result without last");

  // an empty tick reports task zero
  a_none_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ptq_pkg::ST_NONE)) |-> (out_task_id_res == 8'd0))
    else $error("empty tick with nonzero task");

endmodule

bind periodic_timer_queue ptq_checker u_ptq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_task_id_res (out_task_id_res),
  .out_last        (out_last)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_queue testbench
// Drives schedule and tick words through the start/busy handshake and checks
// every result against a sorted timer list kept on the bench side. Directed
// words cover the idle tick, extreme fields, tie order, the full list and a
// large expiry batch. Random phases follow, with and without sender gaps.
// ----------------------------------------------------------------------------
module testbench;

  localparam int QUEUE_DEPTH  = 16;
  // a tick keeps the block busy for at most 16 pops + 16 re-arms
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] task_id;
    logic       last;
  } report_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [7:0]  in_task_id;
  logic [15:0] in_delay;
  logic [15:0] in_interval;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_task_id_res;
  logic        out_last;

  // bench copy of the block state
  ptq_pkg::entry_t timer_list[$];
  logic [31:0]     tick_count;
  report_t         pending_reports[$];
  int              mismatches;
  int              idle_pct;

  periodic_timer_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_task_id      (in_task_id),
    .in_delay        (in_delay),
    .in_interval     (in_interval),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_task_id_res (out_task_id_res),
    .out_last        (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? ptq_pkg::TIME_MAX : sum[31:0];
  endfunction

  // queue one expected report at the tail
  function automatic void expect_report(input report_t r);
    pending_reports.insert(pending_reports.size(), r);
  endfunction

  // new timer goes after every entry expiring at or before it
  function automatic void insert_timer(input ptq_pkg::entry_t e);
    int pos;
    pos = 0;
    while (pos < timer_list.size() && timer_list[pos].expiry <= e.expiry)
      pos++;
    timer_list.insert(pos, e);
  endfunction

  // expected reports for one accepted word
  function automatic void predict_timer_word(input logic action, input logic [7:0] tid,
                                             input logic [15:0] dly, input logic [15:0] ivl);
    ptq_pkg::entry_t fresh;
    ptq_pkg::entry_t rearmed[$];
    int              n_due;
    if (action == ptq_pkg::ACT_SCHEDULE) begin
      if (timer_list.size() >= QUEUE_DEPTH) begin
        expect_report(report_t'{ptq_pkg::ST_DROPPED, tid, 1'b1});
      end else begin
        fresh.expiry  = add_sat(add_sat(tick_count, 32'(dly)), 32'(ivl));
        fresh.task_id = tid;
        fresh.period  = ivl;
        insert_timer(fresh);
        expect_report(report_t'{ptq_pkg::ST_ACCEPTED, tid, 1'b1});
      end
    end else begin
      tick_count = add_sat(tick_count, 32'd1);
      n_due = 0;
      while (n_due < timer_list.size() && n_due < ptq_pkg::MAX_RESULTS &&
             timer_list[n_due].expiry <= tick_count)
        n_due++;
      if (n_due == 0) begin
        expect_report(report_t'{ptq_pkg::ST_NONE, 8'd0, 1'b1});
      end else begin
        for (int i = 0; i < n_due; i++) begin
          expect_report(report_t'{ptq_pkg::ST_EXPIRED, timer_list[i].task_id,
                                  i == n_due - 1});
          if (timer_list[i].period != '0) begin
            fresh        = timer_list[i];
            fresh.expiry = add_sat(tick_count, 32'(timer_list[i].period));
            rearmed.insert(rearmed.size(), fresh);
          end
        end
        repeat (n_due) void'(timer_list.pop_front());
        // re-armed timers go back only after the whole batch, in firing order
        foreach (rearmed[i]) insert_timer(rearmed[i]);
      end
    end
  endfunction

  task automatic note_mismatch(input string what, input report_t want, input report_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s:", $realtime, what,
               " expected status=%0d task=%02h last=%0b,",
               want.status, want.task_id, want.last,
               " got status=%0d task=%02h last=%0b",
               got.status, got.task_id, got.last);
  endtask

  // result checker: each strobed word against the oldest expected report
  always @(posedge clk) begin : check_results
    report_t seen;
    report_t want;
    if (rst_n && out_valid !== 1'b0) begin
      seen = report_t'{out_status, out_task_id_res, out_last};
      if (pending_reports.size() == 0) begin
        note_mismatch("result with nothing expected", '0, seen);
      end else begin
        want = pending_reports.pop_front();
        if (out_valid !== 1'b1 || seen.status !== want.status ||
            seen.task_id !== want.task_id || seen.last !== want.last)
          note_mismatch("wrong result", want, seen);
      end
    end
  end

  // one word: optional idle gap with noise on the fields, then hold until taken
  task automatic send_word(input logic action, input logic [7:0] tid,
                           input logic [15:0] dly, input logic [15:0] ivl);
    while ($urandom_range(99) < idle_pct) begin
      start       = 1'b0;
      in_action   = 1'($urandom);
      in_task_id  = 8'($urandom);
      in_delay    = 16'($urandom);
      in_interval = 16'($urandom);
      @(negedge clk);
    end
    start       = 1'b1;
    in_action   = action;
    in_task_id  = tid;
    in_delay    = dly;
    in_interval = ivl;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_timer_word(action, tid, dly, ivl);
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_word(ptq_pkg::ACT_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // stop sending until every expected report is back and the block settles
  task automatic pause_until_drained();
    start = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // tick with an empty list reports nothing expired
  task automatic test_idle_tick();
    send_tick();
  endtask

  // timer far in the future, lowest task id, top delay
  task automatic test_far_timer();
    send_word(ptq_pkg::ACT_SCHEDULE, 8'h00, 16'hFFFF, 16'h0000);
  endtask

  // four timers due together must fire in arrival order; two of them re-arm
  task automatic test_equal_expiry_order();
    send_word(ptq_pkg::ACT_SCHEDULE, 8'h11, 16'd2, 16'd0);
    send_word(ptq_pkg::ACT_SCHEDULE, 8'h22, 16'd1, 16'd1);
    send_word(ptq_pkg::ACT_SCHEDULE, 8'h33, 16'd0, 16'd2);
    send_word(ptq_pkg::ACT_SCHEDULE, 8'h44, 16'd2, 16'd0);
    send_tick();
    send_tick();
  endtask

  // fill the list, get a drop with all-ones fields, then a batch of fifteen
  task automatic test_full_list_batch();
    for (int i = 0; i < 13; i++)
      send_word(ptq_pkg::ACT_SCHEDULE, 8'(8'h80 + i), 16'd2, 16'd0);
    send_word(ptq_pkg::ACT_SCHEDULE, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_tick();
    send_tick();
  endtask

  // mostly bursts of timers sharing a delay mixed with tick runs
  task automatic test_random_traffic(input int pct, input int n_items);
    int          sent;
    int          pick;
    int          run_len;
    logic [15:0] shared_delay;
    logic [15:0] ivl;
    idle_pct = pct;
    sent     = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        run_len = $urandom_range(1, 4);
        repeat (run_len) send_tick();
      end else if (pick < 87) begin
        run_len      = $urandom_range(1, 5);
        shared_delay = 16'($urandom_range(0, 6));
        repeat (run_len) begin
          ivl = ($urandom_range(99) < 6) ? 16'($urandom_range(1, 8)) : 16'd0;
          send_word(ptq_pkg::ACT_SCHEDULE, 8'($urandom), shared_delay, ivl);
        end
      end else if (pick < 90) begin
        run_len = 1;
        send_word(ptq_pkg::ACT_SCHEDULE, 8'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        // long tick run lets one-shot timers drain
        run_len = $urandom_range(6, 12);
        repeat (run_len) send_tick();
      end
      sent += run_len;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_action   = ptq_pkg::ACT_SCHEDULE;
    in_task_id  = '0;
    in_delay    = '0;
    in_interval = '0;
    tick_count  = '0;
    mismatches  = 0;
    idle_pct    = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_idle_tick();
    test_far_timer();
    test_equal_expiry_order();
    test_full_list_batch();
    pause_until_drained();

    test_random_traffic(0, 50);
    pause_until_drained();
    test_random_traffic(78, 50);
    pause_until_drained();
    test_random_traffic(0, 50);
    test_random_traffic(31, 50);
    pause_until_drained();

    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("[periodic_timer_queue] OK");
    end else begin
      $display("[periodic_timer_queue] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("[periodic_timer_queue] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ptq_pkg.sv
src/ptq_cell.sv
src/periodic_timer_queue.sv
src/ptq_checker.sv
bench/testbench.sv
